@@ rtl/traffic_light_pedestrian_controller_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Traffic light controller assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_PEDESTRIAN_CONTROLLER_UNIT_ASSERT_SVH
`define TRAFFIC_LIGHT_PEDESTRIAN_CONTROLLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Traffic light controller package
// Shared types, phase and event codes, timing register map and lamp decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpc_pkg;

  localparam int TIMER_W   = 16;
  localparam int CFG_W     = 16;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Event codes carried in the func field of an input word.
  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_ON     = 3'd1,
    FUNC_OFF    = 3'd2,
    FUNC_POLICE = 3'd3,
    FUNC_PED    = 3'd4,
    FUNC_CAR    = 3'd5,
    FUNC_FORCE  = 3'd6
  } func_e;

  // External phase codes, as seen on new_state and phase.
  localparam logic [3:0] CODE_OFF          = 4'd0;
  localparam logic [3:0] CODE_BLINK_YELLOW = 4'd1;
  localparam logic [3:0] CODE_YELLOW       = 4'd2;
  localparam logic [3:0] CODE_RED1         = 4'd3;
  localparam logic [3:0] CODE_PGREEN       = 4'd4;
  localparam logic [3:0] CODE_PGREEN_STOP  = 4'd5;
  localparam logic [3:0] CODE_PBLINK       = 4'd6;
  localparam logic [3:0] CODE_RED2         = 4'd7;
  localparam logic [3:0] CODE_REDYELLOW    = 4'd8;
  localparam logic [3:0] CODE_GREEN        = 4'd9;
  localparam logic [3:0] CODE_GREEN_SIG    = 4'd10;

  // Internal phase state, one-hot.
  typedef enum logic [10:0] {
    PH_OFF          = 11'b000_0000_0001,
    PH_BLINK_YELLOW = 11'b000_0000_0010,
    PH_YELLOW       = 11'b000_0000_0100,
    PH_RED1         = 11'b000_0000_1000,
    PH_PGREEN       = 11'b000_0001_0000,
    PH_PGREEN_STOP  = 11'b000_0010_0000,
    PH_PBLINK       = 11'b000_0100_0000,
    PH_RED2         = 11'b000_1000_0000,
    PH_REDYELLOW    = 11'b001_0000_0000,
    PH_GREEN        = 11'b010_0000_0000,
    PH_GREEN_SIG    = 11'b100_0000_0000
  } phase_e;

  // Timing register map.
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_GREEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_BLINK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_YELLOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 3'd7;

  localparam logic [CFG_W-1:0] RST_YELLOW     = 16'd2000;
  localparam logic [CFG_W-1:0] RST_RED_FIRST  = 16'd2000;
  localparam logic [CFG_W-1:0] RST_PED_GREEN  = 16'd5000;
  localparam logic [CFG_W-1:0] RST_PED_BLINK  = 16'd2000;
  localparam logic [CFG_W-1:0] RST_RED_SECOND = 16'd1000;
  localparam logic [CFG_W-1:0] RST_RED_YELLOW = 16'd2000;
  localparam logic [CFG_W-1:0] RST_GREEN      = 16'd5000;
  localparam logic [CFG_W-1:0] RST_SHORT_HOLD = 16'd8;

  // Lamp drive codes.
  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_ON    = 2'd1;
  localparam logic [1:0] LAMP_BLINK = 2'd2;

  typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_bank_t;

  typedef struct packed {
    phase_e             phase;
    logic [TIMER_W-1:0] timer;
    logic               armed;
    logic               ped_req;
    logic               car_stop;
  } ctl_state_t;

  typedef struct packed {
    logic       car_red;
    logic [1:0] car_yellow;
    logic       car_green;
    logic       ped_red;
    logic [1:0] ped_green;
  } lamp_t;

  function automatic logic [3:0] phase_code(phase_e p);
    logic [3:0] c;
    case (p)
      PH_OFF:          c = CODE_OFF;
      PH_BLINK_YELLOW: c = CODE_BLINK_YELLOW;
      PH_YELLOW:       c = CODE_YELLOW;
      PH_RED1:         c = CODE_RED1;
      PH_PGREEN:       c = CODE_PGREEN;
      PH_PGREEN_STOP:  c = CODE_PGREEN_STOP;
      PH_PBLINK:       c = CODE_PBLINK;
      PH_RED2:         c = CODE_RED2;
      PH_REDYELLOW:    c = CODE_REDYELLOW;
      PH_GREEN:        c = CODE_GREEN;
      PH_GREEN_SIG:    c = CODE_GREEN_SIG;
      default:         c = CODE_OFF;
    endcase
    return c;
  endfunction

  function automatic lamp_t phase_lamps(phase_e p);
    lamp_t l;
    l = '{car_red: 1'b0, car_yellow: LAMP_OFF, car_green: 1'b0,
          ped_red: 1'b0, ped_green: LAMP_OFF};
    case (p)
      PH_BLINK_YELLOW: l.car_yellow = LAMP_BLINK;
      PH_YELLOW: begin
        l.car_yellow = LAMP_ON;
        l.ped_red    = 1'b1;
      end
      PH_RED1, PH_RED2: begin
        l.car_red = 1'b1;
        l.ped_red = 1'b1;
      end
      PH_PGREEN, PH_PGREEN_STOP: begin
        l.car_red   = 1'b1;
        l.ped_green = LAMP_ON;
      end
      PH_PBLINK: begin
        l.car_red   = 1'b1;
        l.ped_green = LAMP_BLINK;
      end
      PH_REDYELLOW: begin
        l.car_red    = 1'b1;
        l.car_yellow = LAMP_ON;
        l.ped_red    = 1'b1;
      end
      PH_GREEN, PH_GREEN_SIG: begin
        l.car_green = 1'b1;
        l.ped_red   = 1'b1;
      end
      default: l = l;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/tlpc_if.sv @@
// ----------------------------------------------------------------------------
// Traffic light controller channels
// Valid/ready channels for event words in and lamp status words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlpc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] new_state;

  modport source (output valid, output func, output new_state, input ready);
  modport sink   (input valid, input func, input new_state, output ready);
endinterface

interface tlpc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] phase;
  logic       car_red;
  logic [1:0] car_yellow;
  logic       car_green;
  logic       ped_red;
  logic [1:0] ped_green;
  logic       ped_request_flag;
  logic       car_stopped_flag;

  modport source (
    output valid, output phase, output car_red, output car_yellow, output car_green,
    output ped_red, output ped_green, output ped_request_flag, output car_stopped_flag,
    input ready
  );
  modport sink (
    input valid, input phase, input car_red, input car_yellow, input car_green,
    input ped_red, input ped_green, input ped_request_flag, input car_stopped_flag,
    output ready
  );
endinterface

@@ rtl/traffic_light_pedestrian_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Traffic light controller with pedestrian crossing
// Event-driven phase sequencer with configurable phase times.
// ----------------------------------------------------------------------------
// Usage: each word on in_i is one event (a millisecond tick, switch on, switch
// off, police override, pedestrian button, stopped car, or a forced phase).
// For every accepted event exactly one status word leaves on out_o, giving
// the phase after the event, the lamp drives for cars and pedestrians, and
// the two latched request flags.
// The status word is valid in the cycle after an event is accepted, at one
// word per cycle while out_o is not stalled; the phase update is a single
// level of next-state logic in front of the state and status registers.
// The status register decouples the two sides: in_i.ready is high whenever
// the status register is empty or is being drained in the same cycle, so a
// stalled receiver holds exactly one word and back-pressures the source.
// Reset puts the lights off with the timer disarmed, clears both request
// flags, empties the status register, and loads all eight phase-time registers
// with their defaults. The timing registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i and should only change while no word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "traffic_light_pedestrian_controller_unit_assert.svh"

module traffic_light_pedestrian_controller_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tlpc_pkg::CFG_W-1:0]       cfg_wdata_i,
  tlpc_in_if.sink                          in_i,
  tlpc_out_if.source                       out_o
);

  tlpc_pkg::cfg_bank_t  cfg_q;
  tlpc_pkg::ctl_state_t state_q;
  tlpc_pkg::ctl_state_t state_d;
  logic                 out_vld_q;
  logic                 out_vld_d;
  logic [3:0]           phase_code_q;
  tlpc_pkg::lamp_t      lamps_q;
  logic                 ped_flag_q;
  logic                 car_flag_q;
  logic                 accept;

  // The status register can take a new word when empty or when it drains now.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Phase-time registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[tlpc_pkg::CFG_YELLOW]     <= tlpc_pkg::RST_YELLOW;
      cfg_q[tlpc_pkg::CFG_RED_FIRST]  <= tlpc_pkg::RST_RED_FIRST;
      cfg_q[tlpc_pkg::CFG_PED_GREEN]  <= tlpc_pkg::RST_PED_GREEN;
      cfg_q[tlpc_pkg::CFG_PED_BLINK]  <= tlpc_pkg::RST_PED_BLINK;
      cfg_q[tlpc_pkg::CFG_RED_SECOND] <= tlpc_pkg::RST_RED_SECOND;
      cfg_q[tlpc_pkg::CFG_RED_YELLOW] <= tlpc_pkg::RST_RED_YELLOW;
      cfg_q[tlpc_pkg::CFG_GREEN]      <= tlpc_pkg::RST_GREEN;
      cfg_q[tlpc_pkg::CFG_SHORT_HOLD] <= tlpc_pkg::RST_SHORT_HOLD;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Next-state logic for one event.
  tlpc_step u_step (
    .cur_i       (state_q),
    .func_i      (in_i.func),
    .new_state_i (in_i.new_state),
    .cfg_i       (cfg_q),
    .nxt_o       (state_d)
  );

  // Controller state only moves when an event is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: tlpc_pkg::PH_OFF, timer: '0, armed: 1'b0,
                   ped_req: 1'b0, car_stop: 1'b0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Status word valid: set by an accepted event, cleared once taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Status payload reflects the state after the event.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_code_q <= tlpc_pkg::phase_code(state_d.phase);
      lamps_q      <= tlpc_pkg::phase_lamps(state_d.phase);
      ped_flag_q   <= state_d.ped_req;
      car_flag_q   <= state_d.car_stop;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.phase            = phase_code_q;
  assign out_o.car_red          = lamps_q.car_red;
  assign out_o.car_yellow       = lamps_q.car_yellow;
  assign out_o.car_green        = lamps_q.car_green;
  assign out_o.ped_red          = lamps_q.ped_red;
  assign out_o.ped_green        = lamps_q.ped_green;
  assign out_o.ped_request_flag = ped_flag_q;
  assign out_o.car_stopped_flag = car_flag_q;

  // Off and blinking yellow have no timer, so it can never be armed there.
  `TLPC_ASSERT_NOW(a_untimed_disarmed, (state_q.phase == tlpc_pkg::PH_OFF || state_q.phase == tlpc_pkg::PH_BLINK_YELLOW), !state_q.armed, "timer armed in an untimed phase")

  // Every accepted event leaves a status word behind.
  `TLPC_ASSERT_NEXT(a_accept_fills, accept, out_vld_q, "accepted event produced no status word")

  // A tick in pedestrian green with a stopped car pending ends that phase early.
  `TLPC_ASSERT_NEXT(a_car_stop_early, (accept && in_i.func == tlpc_pkg::FUNC_TICK && state_q.armed && state_q.phase == tlpc_pkg::PH_PGREEN && state_q.car_stop), state_q.phase == tlpc_pkg::PH_PGREEN_STOP, "stopped car did not end pedestrian green")

  // Entering pedestrian green consumes the pedestrian request.
  `TLPC_ASSERT_NOW(a_pgreen_clears_req, (state_q.phase == tlpc_pkg::PH_PGREEN && $past(state_q.phase) != tlpc_pkg::PH_PGREEN), !state_q.ped_req, "pedestrian request still set on entry to pedestrian green")

endmodule

@@ rtl/tlpc_step.sv @@
// ----------------------------------------------------------------------------
// Traffic light controller next-state logic
// Applies one event word to the phase, timer and request flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpc_step (
  input  tlpc_pkg::ctl_state_t cur_i,
  input  logic [2:0]           func_i,
  input  logic [3:0]           new_state_i,
  input  tlpc_pkg::cfg_bank_t  cfg_i,
  output tlpc_pkg::ctl_state_t nxt_o
);

  logic                              enter;
  tlpc_pkg::phase_e                  target;
  tlpc_pkg::phase_e                  forced;
  tlpc_pkg::phase_e                  expire_to;
  logic                              timed;
  logic [tlpc_pkg::CFG_IDX_W-1:0]    src;
  logic [32:0]                       load_wide;

  // Phase reached when the timer runs out.
  always_comb begin
    case (cur_i.phase)
      tlpc_pkg::PH_YELLOW:      expire_to = tlpc_pkg::PH_RED1;
      tlpc_pkg::PH_RED1:        expire_to = tlpc_pkg::PH_PGREEN;
      tlpc_pkg::PH_PGREEN:      expire_to = tlpc_pkg::PH_PBLINK;
      tlpc_pkg::PH_PGREEN_STOP: expire_to = tlpc_pkg::PH_PBLINK;
      tlpc_pkg::PH_PBLINK:      expire_to = tlpc_pkg::PH_RED2;
      tlpc_pkg::PH_RED2:        expire_to = tlpc_pkg::PH_REDYELLOW;
      tlpc_pkg::PH_REDYELLOW:   expire_to = tlpc_pkg::PH_GREEN;
      tlpc_pkg::PH_GREEN:       expire_to = tlpc_pkg::PH_GREEN_SIG;
      tlpc_pkg::PH_GREEN_SIG:   expire_to = tlpc_pkg::PH_YELLOW;
      default:                  expire_to = cur_i.phase;
    endcase
  end

  // Decode of a forced phase code; out-of-range codes are filtered below.
  always_comb begin
    case (new_state_i)
      tlpc_pkg::CODE_OFF:          forced = tlpc_pkg::PH_OFF;
      tlpc_pkg::CODE_BLINK_YELLOW: forced = tlpc_pkg::PH_BLINK_YELLOW;
      tlpc_pkg::CODE_YELLOW:       forced = tlpc_pkg::PH_YELLOW;
      tlpc_pkg::CODE_RED1:         forced = tlpc_pkg::PH_RED1;
      tlpc_pkg::CODE_PGREEN:       forced = tlpc_pkg::PH_PGREEN;
      tlpc_pkg::CODE_PGREEN_STOP:  forced = tlpc_pkg::PH_PGREEN_STOP;
      tlpc_pkg::CODE_PBLINK:       forced = tlpc_pkg::PH_PBLINK;
      tlpc_pkg::CODE_RED2:         forced = tlpc_pkg::PH_RED2;
      tlpc_pkg::CODE_REDYELLOW:    forced = tlpc_pkg::PH_REDYELLOW;
      tlpc_pkg::CODE_GREEN:        forced = tlpc_pkg::PH_GREEN;
      tlpc_pkg::CODE_GREEN_SIG:    forced = tlpc_pkg::PH_GREEN_SIG;
      default:                     forced = tlpc_pkg::PH_OFF;
    endcase
  end

  // Event dispatch: either a phase entry or a flag/timer update.
  always_comb begin
    nxt_o  = cur_i;
    enter  = 1'b0;
    target = tlpc_pkg::PH_OFF;
    case (tlpc_pkg::func_e'(func_i))
      tlpc_pkg::FUNC_TICK: begin
        if (cur_i.armed) begin
          if (cur_i.phase == tlpc_pkg::PH_PGREEN && cur_i.car_stop) begin
            enter  = 1'b1;
            target = tlpc_pkg::PH_PGREEN_STOP;
          end else if (cur_i.phase == tlpc_pkg::PH_GREEN && cur_i.ped_req) begin
            enter  = 1'b1;
            target = tlpc_pkg::PH_GREEN_SIG;
          end else if (cur_i.timer <= tlpc_pkg::TIMER_W'(1)) begin
            enter  = 1'b1;
            target = expire_to;
          end else begin
            nxt_o.timer = cur_i.timer - tlpc_pkg::TIMER_W'(1);
          end
        end
      end
      tlpc_pkg::FUNC_ON: begin
        if (cur_i.phase == tlpc_pkg::PH_OFF) begin
          enter  = 1'b1;
          target = tlpc_pkg::PH_BLINK_YELLOW;
        end
      end
      tlpc_pkg::FUNC_OFF: begin
        enter  = 1'b1;
        target = tlpc_pkg::PH_OFF;
      end
      tlpc_pkg::FUNC_POLICE: begin
        if (cur_i.phase == tlpc_pkg::PH_BLINK_YELLOW) begin
          enter  = 1'b1;
          target = tlpc_pkg::PH_YELLOW;
        end else if (cur_i.phase != tlpc_pkg::PH_OFF) begin
          enter  = 1'b1;
          target = tlpc_pkg::PH_BLINK_YELLOW;
        end
      end
      tlpc_pkg::FUNC_PED: nxt_o.ped_req = 1'b1;
      tlpc_pkg::FUNC_CAR: nxt_o.car_stop = 1'b1;
      tlpc_pkg::FUNC_FORCE: begin
        if (new_state_i <= tlpc_pkg::CODE_GREEN_SIG) begin
          enter  = 1'b1;
          target = forced;
        end
      end
      default: nxt_o = cur_i;
    endcase

    // Which timing register loads the timer on entry.
    timed = 1'b1;
    case (target)
      tlpc_pkg::PH_YELLOW:      src = tlpc_pkg::CFG_YELLOW;
      tlpc_pkg::PH_RED1:        src = tlpc_pkg::CFG_RED_FIRST;
      tlpc_pkg::PH_PGREEN:      src = tlpc_pkg::CFG_PED_GREEN;
      tlpc_pkg::PH_PGREEN_STOP: src = tlpc_pkg::CFG_SHORT_HOLD;
      tlpc_pkg::PH_PBLINK:      src = tlpc_pkg::CFG_PED_BLINK;
      tlpc_pkg::PH_RED2:        src = tlpc_pkg::CFG_RED_SECOND;
      tlpc_pkg::PH_REDYELLOW:   src = tlpc_pkg::CFG_RED_YELLOW;
      tlpc_pkg::PH_GREEN:       src = tlpc_pkg::CFG_GREEN;
      tlpc_pkg::PH_GREEN_SIG:   src = tlpc_pkg::CFG_SHORT_HOLD;
      default: begin
        timed = 1'b0;
        src   = tlpc_pkg::CFG_YELLOW;
      end
    endcase
    load_wide = 33'(cfg_i[src]);

    if (enter) begin
      nxt_o.phase = target;
      nxt_o.armed = timed;
      if (target == tlpc_pkg::PH_PGREEN) begin
        nxt_o.ped_req = 1'b0;
      end
      if (target == tlpc_pkg::PH_GREEN) begin
        nxt_o.car_stop = 1'b0;
      end
      if (timed) begin
        // A loaded value saturates at what the timer can hold.
        if (load_wide > 33'(tlpc_pkg::TIMER_MAX)) begin
          nxt_o.timer = tlpc_pkg::TIMER_MAX;
        end else begin
          nxt_o.timer = load_wide[tlpc_pkg::TIMER_W-1:0];
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Traffic light controller testbench
// Drives event words into the controller and checks every status word against
// a cycle-free software copy of the phase sequencer, across several timing
// register settings, with random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Codes that the package does not name: the spare event code and the
  // phase numbers above the last real phase, which a force must ignore.
  localparam logic [2:0] FUNC_UNUSED   = 3'd7;
  localparam logic [3:0] NS_FIRST_BAD  = 4'd11;
  localparam logic [3:0] NS_LAST_BAD   = 4'd15;

  localparam int NUM_DIRECTED = 28;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 60;

  // One status word as it leaves the block.
  typedef struct packed {
    logic [3:0] phase;
    logic       car_red;
    logic [1:0] car_yellow;
    logic       car_green;
    logic       ped_red;
    logic [1:0] ped_green;
    logic       walk_flag;
    logic       halt_flag;
  } light_status_t;

  // One row of the directed part. Where typed is set, the phase and the two
  // flags of the row are the expected values and override the prediction.
  typedef struct packed {
    logic [2:0] fn;
    logic [3:0] ns;
    logic       typed;
    logic [3:0] phase;
    logic       walk;
    logic       halt;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Nothing happens while the lights are off.
    '{tlpc_pkg::FUNC_TICK, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, NS_LAST_BAD, 1'b1, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{FUNC_UNUSED, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    // Switch on, a second switch on, and a tick with the timer disarmed.
    '{tlpc_pkg::FUNC_ON, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_BLINK_YELLOW, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_ON, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_BLINK_YELLOW, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_TICK, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_BLINK_YELLOW, 1'b0, 1'b0},
    // Police toggles between blinking and the timed sequence.
    '{tlpc_pkg::FUNC_POLICE, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_YELLOW, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_TICK, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_YELLOW, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_POLICE, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_BLINK_YELLOW, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_OFF, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_POLICE, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    // Reports latch their flags in any phase.
    '{tlpc_pkg::FUNC_PED, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_OFF, 1'b1, 1'b0},
    '{tlpc_pkg::FUNC_CAR, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_OFF, 1'b1, 1'b1},
    // Entering pedestrian green clears the walk request; a stopped car
    // ends it at the next tick.
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_PGREEN, 1'b1, tlpc_pkg::CODE_PGREEN, 1'b0, 1'b1},
    '{tlpc_pkg::FUNC_TICK, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_PGREEN_STOP, 1'b0, 1'b1},
    // Entering car green clears the stopped car; a walk request ends it.
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_GREEN, 1'b1, tlpc_pkg::CODE_GREEN, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_PED, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_GREEN, 1'b1, 1'b0},
    '{tlpc_pkg::FUNC_TICK, tlpc_pkg::CODE_OFF, 1'b1, tlpc_pkg::CODE_GREEN_SIG, 1'b1, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_GREEN_SIG, 1'b1, tlpc_pkg::CODE_GREEN_SIG,
      1'b1, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, NS_FIRST_BAD, 1'b1, tlpc_pkg::CODE_GREEN_SIG, 1'b1, 1'b0},
    // Every remaining phase, forced once.
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_RED1, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_PGREEN_STOP, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_PBLINK, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_RED2, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_REDYELLOW, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_YELLOW, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_BLINK_YELLOW, 1'b0, tlpc_pkg::CODE_OFF,
      1'b0, 1'b0},
    '{tlpc_pkg::FUNC_FORCE, tlpc_pkg::CODE_OFF, 1'b0, tlpc_pkg::CODE_OFF, 1'b0, 1'b0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [tlpc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tlpc_pkg::CFG_W-1:0]     cfg_wdata_i;

  tlpc_in_if  in_ch ();
  tlpc_out_if out_ch ();

  traffic_light_pedestrian_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // The period is 12 ns; the clock starts low so the first rising edge is
  // at 6 ns and inputs change on falling edges.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow copy of the sequencer. It is advanced once per accepted event
  // word, at the same rising edge where the block accepts it.
  // --------------------------------------------------------------------------
  logic [3:0]                   light_phase;
  logic [tlpc_pkg::TIMER_W-1:0] phase_ticks;
  logic                         ticks_armed;
  logic                         walk_pending;
  logic                         car_halted;
  logic [tlpc_pkg::CFG_W-1:0]   phase_time [tlpc_pkg::NUM_CFG];

  // Timing register that loads the timer when a phase is entered.
  function automatic logic [tlpc_pkg::CFG_IDX_W-1:0] timing_reg_for(logic [3:0] p);
    case (p)
      tlpc_pkg::CODE_YELLOW:    return tlpc_pkg::CFG_YELLOW;
      tlpc_pkg::CODE_RED1:      return tlpc_pkg::CFG_RED_FIRST;
      tlpc_pkg::CODE_PGREEN:    return tlpc_pkg::CFG_PED_GREEN;
      tlpc_pkg::CODE_PBLINK:    return tlpc_pkg::CFG_PED_BLINK;
      tlpc_pkg::CODE_RED2:      return tlpc_pkg::CFG_RED_SECOND;
      tlpc_pkg::CODE_REDYELLOW: return tlpc_pkg::CFG_RED_YELLOW;
      tlpc_pkg::CODE_GREEN:     return tlpc_pkg::CFG_GREEN;
      default:                  return tlpc_pkg::CFG_SHORT_HOLD;
    endcase
  endfunction

  // Phase that follows when the timer runs out. The early exit from
  // pedestrian green shares its successor with the phase it cuts short.
  function automatic logic [3:0] phase_after(logic [3:0] p);
    case (p)
      tlpc_pkg::CODE_YELLOW:      return tlpc_pkg::CODE_RED1;
      tlpc_pkg::CODE_RED1:        return tlpc_pkg::CODE_PGREEN;
      tlpc_pkg::CODE_PGREEN:      return tlpc_pkg::CODE_PBLINK;
      tlpc_pkg::CODE_PGREEN_STOP: return tlpc_pkg::CODE_PBLINK;
      tlpc_pkg::CODE_PBLINK:      return tlpc_pkg::CODE_RED2;
      tlpc_pkg::CODE_RED2:        return tlpc_pkg::CODE_REDYELLOW;
      tlpc_pkg::CODE_REDYELLOW:   return tlpc_pkg::CODE_GREEN;
      tlpc_pkg::CODE_GREEN:       return tlpc_pkg::CODE_GREEN_SIG;
      tlpc_pkg::CODE_GREEN_SIG:   return tlpc_pkg::CODE_YELLOW;
      default:                    return p;
    endcase
  endfunction

  // Any entry, also into the current phase, disarms the timer and then
  // reloads it for the timed phases (yellow and everything after it).
  function automatic void enter_light_phase(logic [3:0] p);
    int unsigned ld_val;
    if (p > tlpc_pkg::CODE_GREEN_SIG) return;
    light_phase = p;
    if (p == tlpc_pkg::CODE_PGREEN) walk_pending = 1'b0;
    if (p == tlpc_pkg::CODE_GREEN)  car_halted   = 1'b0;
    ticks_armed = 1'b0;
    if (p >= tlpc_pkg::CODE_YELLOW) begin
      // A loaded time saturates at what the timer can hold.
      ld_val = 32'(phase_time[timing_reg_for(p)]);
      if (ld_val > 32'(tlpc_pkg::TIMER_MAX)) ld_val = 32'(tlpc_pkg::TIMER_MAX);
      phase_ticks = tlpc_pkg::TIMER_W'(ld_val);
      ticks_armed = 1'b1;
    end
  endfunction

  function automatic void count_tick();
    if (!ticks_armed) return;
    if (light_phase == tlpc_pkg::CODE_PGREEN && car_halted) begin
      enter_light_phase(tlpc_pkg::CODE_PGREEN_STOP);
    end else if (light_phase == tlpc_pkg::CODE_GREEN && walk_pending) begin
      enter_light_phase(tlpc_pkg::CODE_GREEN_SIG);
    end else if (phase_ticks <= 1) begin
      // A loaded value of zero still lasts one tick.
      enter_light_phase(phase_after(light_phase));
    end else begin
      phase_ticks = phase_ticks - 1'b1;
    end
  endfunction

  // Applies one event and returns the status word it should produce.
  function automatic light_status_t step_lights(logic [2:0] fn, logic [3:0] ns);
    light_status_t s;
    logic [3:0]    p;
    case (fn)
      tlpc_pkg::FUNC_TICK: count_tick();
      tlpc_pkg::FUNC_ON: begin
        if (light_phase == tlpc_pkg::CODE_OFF) enter_light_phase(tlpc_pkg::CODE_BLINK_YELLOW);
      end
      tlpc_pkg::FUNC_OFF: enter_light_phase(tlpc_pkg::CODE_OFF);
      tlpc_pkg::FUNC_POLICE: begin
        if (light_phase == tlpc_pkg::CODE_BLINK_YELLOW)
          enter_light_phase(tlpc_pkg::CODE_YELLOW);
        else if (light_phase != tlpc_pkg::CODE_OFF)
          enter_light_phase(tlpc_pkg::CODE_BLINK_YELLOW);
      end
      tlpc_pkg::FUNC_PED:   walk_pending = 1'b1;
      tlpc_pkg::FUNC_CAR:   car_halted   = 1'b1;
      tlpc_pkg::FUNC_FORCE: enter_light_phase(ns);
      default:              ;
    endcase
    p = light_phase;
    s.phase      = p;
    s.car_red    = (p >= tlpc_pkg::CODE_RED1) && (p <= tlpc_pkg::CODE_REDYELLOW);
    s.car_green  = (p >= tlpc_pkg::CODE_GREEN);
    s.car_yellow = (p == tlpc_pkg::CODE_BLINK_YELLOW) ? tlpc_pkg::LAMP_BLINK :
                   (p == tlpc_pkg::CODE_YELLOW || p == tlpc_pkg::CODE_REDYELLOW) ?
                   tlpc_pkg::LAMP_ON : tlpc_pkg::LAMP_OFF;
    s.ped_green  = (p == tlpc_pkg::CODE_PBLINK) ? tlpc_pkg::LAMP_BLINK :
                   (p == tlpc_pkg::CODE_PGREEN || p == tlpc_pkg::CODE_PGREEN_STOP) ?
                   tlpc_pkg::LAMP_ON : tlpc_pkg::LAMP_OFF;
    s.ped_red    = (p == tlpc_pkg::CODE_YELLOW) || (p == tlpc_pkg::CODE_RED1) ||
                   (p == tlpc_pkg::CODE_RED2) || (p == tlpc_pkg::CODE_REDYELLOW) ||
                   (p >= tlpc_pkg::CODE_GREEN);
    s.walk_flag  = walk_pending;
    s.halt_flag  = car_halted;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Status words still owed by the block, oldest first, and the run's books.
  // --------------------------------------------------------------------------
  light_status_t status_pending [$];
  int            fail_count;
  int            words_checked;
  int            events_sent;
  int            settings_used;
  int            stall_cycles = 0;
  bit            phase_reached [11];

  // Set by the sender together with each event word; the acceptance monitor
  // reads them at the rising edge where the word goes in.
  logic          row_typed;
  logic [3:0]    row_phase;
  logic          row_walk;
  logic          row_halt;

  // Random gaps and back-pressure are only inserted while this is set.
  bit            idle_on;

  task automatic report_mismatch(string field, int got, int want);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] status word %0d: %s is %0d, expected %0d",
               $time, words_checked, field, got, want);
    fail_count++;
  endtask

  light_status_t got_word;
  light_status_t want_word;
  light_status_t next_word;

  // Output check, then input prediction, in one process so that the order of
  // the two is fixed. The watchdog lives here too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles = stall_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        stall_cycles = 0;
        got_word = '{out_ch.phase, out_ch.car_red, out_ch.car_yellow, out_ch.car_green,
                     out_ch.ped_red, out_ch.ped_green, out_ch.ped_request_flag,
                     out_ch.car_stopped_flag};
        if (status_pending.size() == 0) begin
          report_mismatch("word with nothing pending, phase", got_word.phase, 0);
        end else begin
          want_word = status_pending.pop_front();
          if (got_word.phase !== want_word.phase)
            report_mismatch("phase", got_word.phase, want_word.phase);
          if (got_word.car_red !== want_word.car_red)
            report_mismatch("car_red", got_word.car_red, want_word.car_red);
          if (got_word.car_yellow !== want_word.car_yellow)
            report_mismatch("car_yellow", got_word.car_yellow, want_word.car_yellow);
          if (got_word.car_green !== want_word.car_green)
            report_mismatch("car_green", got_word.car_green, want_word.car_green);
          if (got_word.ped_red !== want_word.ped_red)
            report_mismatch("ped_red", got_word.ped_red, want_word.ped_red);
          if (got_word.ped_green !== want_word.ped_green)
            report_mismatch("ped_green", got_word.ped_green, want_word.ped_green);
          if (got_word.walk_flag !== want_word.walk_flag)
            report_mismatch("ped_request_flag", got_word.walk_flag, want_word.walk_flag);
          if (got_word.halt_flag !== want_word.halt_flag)
            report_mismatch("car_stopped_flag", got_word.halt_flag, want_word.halt_flag);
          words_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        stall_cycles = 0;
        next_word = step_lights(in_ch.func, in_ch.new_state);
        // Directed rows with typed expectations replace the predicted phase
        // and flags, so a slip in the shadow copy shows up as well.
        if (row_typed) begin
          next_word.phase     = row_phase;
          next_word.walk_flag = row_walk;
          next_word.halt_flag = row_halt;
        end
        phase_reached[next_word.phase] = 1'b1;
        status_pending.push_back(next_word);
        events_sent++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d status words pending",
                 STALL_LIMIT, status_pending.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: ready drops in random bursts while idling is on, and stays
  // high otherwise.
  int ready_hold;
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Every task here is entered and left at a falling edge.
  // --------------------------------------------------------------------------
  task automatic push_event(logic [2:0] fn, logic [3:0] ns);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.new_state <= ns;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    // Sender gap: valid stays low for a random burst.
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  // Waits until every event word has been answered. Each event yields one
  // status word, so a short margin is enough.
  task automatic wait_drained();
    while (status_pending.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  logic [tlpc_pkg::CFG_W-1:0] next_timing [tlpc_pkg::NUM_CFG];

  // Writes all eight phase times while the block is idle.
  task automatic load_timing();
    in_ch.valid <= 1'b0;
    wait_drained();
    for (int i = 0; i < tlpc_pkg::NUM_CFG; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= tlpc_pkg::CFG_IDX_W'(i);
      cfg_wdata_i <= next_timing[i];
      @(negedge clk_i);
      phase_time[i] = next_timing[i];
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // One random event word. From the off and blinking phases the word is
  // often the step toward the timed sequence, so most of the run is
  // spent cycling through it; the rest is ticks, reports and noise.
  task automatic send_random_event();
    logic [2:0] fn;
    logic [3:0] ns;
    int         roll;
    roll = $urandom_range(0, 99);
    if (light_phase == tlpc_pkg::CODE_OFF && roll < 40) begin
      fn = tlpc_pkg::FUNC_ON;
    end else if (light_phase == tlpc_pkg::CODE_BLINK_YELLOW && roll < 35) begin
      fn = tlpc_pkg::FUNC_POLICE;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 68)      fn = tlpc_pkg::FUNC_TICK;
      else if (roll < 75) fn = tlpc_pkg::FUNC_PED;
      else if (roll < 82) fn = tlpc_pkg::FUNC_CAR;
      else if (roll < 88) fn = tlpc_pkg::FUNC_FORCE;
      else if (roll < 91) fn = tlpc_pkg::FUNC_ON;
      else if (roll < 93) fn = tlpc_pkg::FUNC_OFF;
      else if (roll < 97) fn = tlpc_pkg::FUNC_POLICE;
      else                fn = FUNC_UNUSED;
    end
    if (fn == tlpc_pkg::FUNC_FORCE && $urandom_range(0, 9) != 0)
      ns = 4'($urandom_range(tlpc_pkg::CODE_OFF, tlpc_pkg::CODE_GREEN_SIG));
    else
      ns = 4'($urandom_range(0, 15));
    row_typed = 1'b0;
    push_event(fn, ns);
  endtask

  task automatic run_events(int count);
    repeat (count) send_random_event();
  endtask

  int reached;

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = tlpc_pkg::FUNC_TICK;
    in_ch.new_state = tlpc_pkg::CODE_OFF;
    out_ch.ready    = 1'b0;
    ready_hold      = 0;
    idle_on         = 1'b1;
    row_typed       = 1'b0;
    row_phase       = tlpc_pkg::CODE_OFF;
    row_walk        = 1'b0;
    row_halt        = 1'b0;
    fail_count      = 0;
    words_checked   = 0;
    events_sent     = 0;
    settings_used   = 1;

    // The shadow copy starts from the reset state, default times included.
    light_phase   = tlpc_pkg::CODE_OFF;
    phase_ticks   = '0;
    ticks_armed   = 1'b0;
    walk_pending  = 1'b0;
    car_halted    = 1'b0;
    phase_time[tlpc_pkg::CFG_YELLOW]     = tlpc_pkg::RST_YELLOW;
    phase_time[tlpc_pkg::CFG_RED_FIRST]  = tlpc_pkg::RST_RED_FIRST;
    phase_time[tlpc_pkg::CFG_PED_GREEN]  = tlpc_pkg::RST_PED_GREEN;
    phase_time[tlpc_pkg::CFG_PED_BLINK]  = tlpc_pkg::RST_PED_BLINK;
    phase_time[tlpc_pkg::CFG_RED_SECOND] = tlpc_pkg::RST_RED_SECOND;
    phase_time[tlpc_pkg::CFG_RED_YELLOW] = tlpc_pkg::RST_RED_YELLOW;
    phase_time[tlpc_pkg::CFG_GREEN]      = tlpc_pkg::RST_GREEN;
    phase_time[tlpc_pkg::CFG_SHORT_HOLD] = tlpc_pkg::RST_SHORT_HOLD;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, run with the reset-default phase times.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row_typed = DIRECTED_ROWS[r].typed;
      row_phase = DIRECTED_ROWS[r].phase;
      row_walk  = DIRECTED_ROWS[r].walk;
      row_halt  = DIRECTED_ROWS[r].halt;
      push_event(DIRECTED_ROWS[r].fn, DIRECTED_ROWS[r].ns);
    end

    // Every phase time zero: each timed phase lasts a single tick.
    foreach (next_timing[i]) next_timing[i] = '0;
    load_timing();
    run_events(220);

    // Every phase time at its largest value; nothing expires, but every
    // timer bit is loaded high.
    foreach (next_timing[i]) next_timing[i] = '1;
    load_timing();
    run_events(40);

    // Very short phases, so the full loop turns over many times.
    foreach (next_timing[i]) next_timing[i] = tlpc_pkg::CFG_W'($urandom_range(0, 5));
    load_timing();
    run_events(250);

    // Somewhat longer phases. Partway through, the sender holds off until
    // every status word is back, then carries on from a quiet block.
    foreach (next_timing[i]) next_timing[i] = tlpc_pkg::CFG_W'($urandom_range(1, 12));
    load_timing();
    run_events(120);
    in_ch.valid <= 1'b0;
    wait_drained();
    run_events(130);

    // Mixed extremes: car green only ends on a walk request, and both
    // early-exit holds last one tick.
    foreach (next_timing[i]) next_timing[i] = tlpc_pkg::CFG_W'($urandom_range(0, 8));
    next_timing[tlpc_pkg::CFG_GREEN]      = '1;
    next_timing[tlpc_pkg::CFG_SHORT_HOLD] = '0;
    load_timing();
    run_events(250);

    // Final stretch at full rate on both sides.
    foreach (next_timing[i]) next_timing[i] = tlpc_pkg::CFG_W'($urandom_range(0, 4));
    load_timing();
    idle_on = 1'b0;
    run_events(300);

    in_ch.valid <= 1'b0;
    while (status_pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    reached = 0;
    foreach (phase_reached[i]) reached += phase_reached[i];
    $display("Sent %0d event words under %0d timing settings; checked %0d status words.",
             events_sent, settings_used, words_checked);
    $display("Reached %0d of 11 phases; %0d mismatches.", reached, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tlpc_pkg.sv
rtl/tlpc_if.sv
rtl/tlpc_step.sv
rtl/traffic_light_pedestrian_controller_unit.sv
tb/sv/tb_top.sv
